// ----- sv/pcl_pkg.sv -----
// polygon plane clipper package: side codes, register indexes, field widths
// and the layout of one stored vertex entry
// no dependencies
package pcl_pkg;

  localparam int COORD_W = 32;
  localparam int DIST_W  = 48;
  localparam int EPS_W   = 17;
  localparam int SIDE_W  = 2;
  localparam int FRAC_W  = 32;
  localparam int CFG_IDX_W = 3;

  // vertex side codes
  localparam logic [SIDE_W-1:0] POS_ON    = 2'd0;
  localparam logic [SIDE_W-1:0] POS_FRONT = 2'd1;
  localparam logic [SIDE_W-1:0] POS_BACK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_DIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_EPSILON = 3'd4;

  // one stored vertex: coordinates, clamped plane distance, side
  typedef struct packed {
    logic [SIDE_W-1:0]         side;
    logic signed [DIST_W-1:0]  plane_d;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // true on an edge that runs from front to back or from back to front
  function automatic logic crosses(input logic [SIDE_W-1:0] a, input logic [SIDE_W-1:0] b);
    crosses = ((a == POS_FRONT) && (b == POS_BACK)) ||
              ((a == POS_BACK) && (b == POS_FRONT));
  endfunction

endpackage

// ----- sv/pcl_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/polygon_plane_clipper.sv -----
// polygon clipper against one plane, top level
// depends on pcl_pkg and pcl_ram
//
// Vertices enter on the in_ stream (tdata = x, y, z, Q16.16 each; tlast marks
// the final vertex). Each vertex passes through accept, three steps of one
// shared 32x32 multiplier for the plane distance, and a write of the vertex,
// its distance and side into the vertex store. Up to MAX_VERTS vertices are
// stored; further ones are dropped and flag the polygon as overflowed.
// After the final vertex the clipped polygon leaves on the out_ stream
// (tdata = x, y, z; tlast = final vertex; tuser = culled, overflowed).
// The emit pass reads each stored vertex and its successor from two copies
// of the store; each crossing edge adds the 32-step restoring divider and
// six multiply/add steps of the interpolation. A culled polygon gives one
// result with zero coordinates. No new vertex is taken until the pass ends.
// An output register holds each result; while out_tready is low the pass
// waits on it. Configuration writes on the cfg_ port are always ready and
// take effect at once; they are meant only between polygons. Reset (rst_n
// low, synchronous) restores the register defaults and empties the polygon.
module polygon_plane_clipper #(
  parameter int MAX_VERTS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  // input vertices
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [95:0]                     in_tdata,   // vx, vy, vz
  input  logic                            in_tlast,
  // clipped vertices
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [95:0]                     out_tdata,  // ox, oy, oz
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser   // culled, overflowed
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int PW = $clog2(2 * MAX_VERTS + 1);
  localparam int ACC_W = pcl_pkg::DIST_W + 2;
  localparam int QC_W = $clog2(pcl_pkg::FRAC_W);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_CULL  = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_VTX   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_LMUL  = 4'd9;
  localparam logic [3:0] S_LADD  = 4'd10;
  localparam logic [3:0] S_EMITL = 4'd11;

  localparam logic signed [ACC_W-1:0] DMAX =
    {{(ACC_W - pcl_pkg::DIST_W + 1){1'b0}}, {(pcl_pkg::DIST_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DMIN = ~DMAX;

  logic [3:0] state_r;

  // configuration registers
  logic signed [31:0] nx_r, ny_r, nz_r, pd_r;
  logic [pcl_pkg::EPS_W-1:0] eps_r;

  // polygon bookkeeping
  logic [CW-1:0] vcount_r;
  logic front_r, back_r, inovf_r;
  logic [pcl_pkg::SIDE_W-1:0] first_side_r, prev_side_r;
  logic [PW-1:0] produced_r;
  logic [CW-1:0] kept_r, emit_cnt_r;
  logic ovf_r;

  // vertex load path
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic last_r;
  logic [1:0] mc_r;
  logic signed [ACC_W-1:0] acc_r;

  // emit pass
  logic [AW-1:0] idx_r;
  logic [49:0] rem_r;
  logic [48:0] den_r;
  logic [pcl_pkg::FRAC_W-1:0] q_r;
  logic [QC_W-1:0] qc_r;
  logic [1:0] lc_r;
  logic [63:0] prod_r;
  logic neg_r;
  logic signed [31:0] lerp_r [3];

  // output register
  logic out_valid_r;
  logic [95:0] out_data_r;
  logic out_last_r, out_culled_r, out_ovf_r;

  pcl_pkg::entry_t wr_entry, rd_i, rd_j;
  logic wr_en;
  logic [AW-1:0] j_addr;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_culled_r};

  // successor index with wrap to the first vertex
  logic [CW-1:0] idx_next;
  assign idx_next = CW'(idx_r) + CW'(1);
  assign j_addr   = (idx_next < vcount_r) ? idx_next[AW-1:0] : '0;

  // plane distance product for the selected coordinate
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] dprod;
  always_comb begin
    case (mc_r)
      2'd0:    begin mul_a = vx_r; mul_b = nx_r; end
      2'd1:    begin mul_a = vy_r; mul_b = ny_r; end
      default: begin mul_a = vz_r; mul_b = nz_r; end
    endcase
    dprod = mul_a * mul_b;
  end

  // distance clamp and side
  logic signed [ACC_W-1:0] d_full, d_sat, eps_s;
  logic [pcl_pkg::SIDE_W-1:0] side_new;
  always_comb begin
    d_full = acc_r - ACC_W'(pd_r);
    if (d_full > DMAX) d_sat = DMAX;
    else if (d_full < DMIN) d_sat = DMIN;
    else d_sat = d_full;
    eps_s = ACC_W'($signed({1'b0, eps_r}));
    if (d_sat < -eps_s) side_new = pcl_pkg::POS_BACK;
    else if (d_sat > eps_s) side_new = pcl_pkg::POS_FRONT;
    else side_new = pcl_pkg::POS_ON;
  end

  assign wr_en = (state_r == S_WRITE) && (vcount_r < CW'(MAX_VERTS));
  always_comb begin
    wr_entry.side    = side_new;
    wr_entry.plane_d = d_sat[pcl_pkg::DIST_W-1:0];
    wr_entry.z       = vz_r;
    wr_entry.y       = vy_r;
    wr_entry.x       = vx_r;
  end

  // two copies of the store so an edge reads both ends at once
  pcl_ram #(.WIDTH(pcl_pkg::ENTRY_W), .DEPTH(MAX_VERTS)) u_store_i (
    .clk(clk), .wr_en(wr_en), .wr_addr(vcount_r[AW-1:0]), .wr_data(wr_entry),
    .rd_addr(idx_r), .rd_data(rd_i)
  );
  pcl_ram #(.WIDTH(pcl_pkg::ENTRY_W), .DEPTH(MAX_VERTS)) u_store_j (
    .clk(clk), .wr_en(wr_en), .wr_addr(vcount_r[AW-1:0]), .wr_data(wr_entry),
    .rd_addr(j_addr), .rd_data(rd_j)
  );

  // distance magnitudes of the edge ends
  logic [pcl_pkg::DIST_W-1:0] mag_i, mag_j;
  assign mag_i = rd_i.plane_d[pcl_pkg::DIST_W-1] ? (~rd_i.plane_d + 1'b1) : rd_i.plane_d;
  assign mag_j = rd_j.plane_d[pcl_pkg::DIST_W-1] ? (~rd_j.plane_d + 1'b1) : rd_j.plane_d;

  // one restoring division step
  logic [49:0] rem_sh, rem_sub;
  logic q_bit;
  assign rem_sh  = {rem_r[48:0], 1'b0};
  assign q_bit   = rem_sh >= {1'b0, den_r};
  assign rem_sub = q_bit ? rem_sh - {1'b0, den_r} : rem_sh;

  // interpolation operands for the selected coordinate
  logic signed [31:0] la, lb;
  logic signed [32:0] ldiff, lneg;
  logic [31:0] lmag, loff;
  always_comb begin
    case (lc_r)
      2'd0:    begin la = rd_i.x; lb = rd_j.x; end
      2'd1:    begin la = rd_i.y; lb = rd_j.y; end
      default: begin la = rd_i.z; lb = rd_j.z; end
    endcase
    ldiff = 33'(lb) - 33'(la);
    lneg  = -ldiff;
    lmag  = ldiff[32] ? lneg[31:0] : ldiff[31:0];
    loff  = prod_r[63:32];
  end

  logic slot_free;
  assign slot_free = !out_valid_r || out_tready;

  // a new result enters the output register this cycle
  logic emit_now;
  assign emit_now = slot_free &&
                    ((state_r == S_CULL) || (state_r == S_EMITL) ||
                     ((state_r == S_VTX) && (emit_cnt_r != kept_r) &&
                      (rd_i.side != pcl_pkg::POS_BACK)));

  logic [CW-1:0] emit_inc;
  assign emit_inc = emit_cnt_r + CW'(1);

  logic [PW-1:0] produced_fin;
  assign produced_fin = produced_r + PW'(pcl_pkg::crosses(prev_side_r, first_side_r));

  // control, bookkeeping and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      nx_r        <= '0;
      ny_r        <= '0;
      nz_r        <= 32'sd65536;
      pd_r        <= '0;
      eps_r       <= pcl_pkg::EPS_W'(4096);
      vcount_r    <= '0;
      front_r     <= 1'b0;
      back_r      <= 1'b0;
      inovf_r     <= 1'b0;
      produced_r  <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_tready && !emit_now) begin
        out_valid_r <= 1'b0;
      end

      // configuration transaction
      if (cfg_valid) begin
        unique case (cfg_index)
          pcl_pkg::CFG_NORMAL_X:   nx_r  <= cfg_data;
          pcl_pkg::CFG_NORMAL_Y:   ny_r  <= cfg_data;
          pcl_pkg::CFG_NORMAL_Z:   nz_r  <= cfg_data;
          pcl_pkg::CFG_PLANE_DIST: pd_r  <= cfg_data;
          pcl_pkg::CFG_ON_EPSILON: eps_r <= cfg_data[pcl_pkg::EPS_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_tvalid) begin
            vx_r    <= in_tdata[31:0];
            vy_r    <= in_tdata[63:32];
            vz_r    <= in_tdata[95:64];
            last_r  <= in_tlast;
            mc_r    <= '0;
            acc_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= acc_r + ACC_W'($signed(dprod[63:16]));
          mc_r  <= mc_r + 2'd1;
          if (mc_r == 2'd2) state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (vcount_r < CW'(MAX_VERTS)) begin
            vcount_r    <= vcount_r + CW'(1);
            prev_side_r <= side_new;
            if (vcount_r == '0) first_side_r <= side_new;
            if (side_new == pcl_pkg::POS_BACK) back_r <= 1'b1;
            if (side_new == pcl_pkg::POS_FRONT) front_r <= 1'b1;
            produced_r <= produced_r
                        + PW'(side_new != pcl_pkg::POS_BACK)
                        + PW'((vcount_r != '0) && pcl_pkg::crosses(prev_side_r, side_new));
          end else begin
            inovf_r <= 1'b1;
          end
          state_r <= last_r ? S_START : S_LOAD;
        end
        S_START: begin
          produced_r <= produced_fin;
          kept_r     <= (produced_fin > PW'(MAX_VERTS)) ? CW'(MAX_VERTS)
                                                        : produced_fin[CW-1:0];
          ovf_r      <= inovf_r || (produced_fin > PW'(MAX_VERTS));
          emit_cnt_r <= '0;
          idx_r      <= '0;
          if (!front_r || (back_r && (produced_fin < PW'(3)))) state_r <= S_CULL;
          else state_r <= S_FETCH;
        end
        S_CULL: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= '0;
            out_last_r   <= 1'b1;
            out_culled_r <= 1'b1;
            out_ovf_r    <= inovf_r;
            vcount_r     <= '0;
            front_r      <= 1'b0;
            back_r       <= 1'b0;
            inovf_r      <= 1'b0;
            produced_r   <= '0;
            state_r      <= S_LOAD;
          end
        end
        S_FETCH: begin
          state_r <= S_VTX;
        end
        S_VTX: begin
          if (emit_cnt_r == kept_r) begin
            vcount_r   <= '0;
            front_r    <= 1'b0;
            back_r     <= 1'b0;
            inovf_r    <= 1'b0;
            produced_r <= '0;
            state_r    <= S_LOAD;
          end else if (rd_i.side == pcl_pkg::POS_BACK) begin
            state_r <= S_CHK;
          end else if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= {rd_i.z, rd_i.y, rd_i.x};
            out_last_r   <= (emit_inc == kept_r);
            out_culled_r <= 1'b0;
            out_ovf_r    <= ovf_r;
            emit_cnt_r   <= emit_inc;
            state_r      <= S_CHK;
          end
        end
        S_CHK: begin
          if (emit_cnt_r == kept_r) begin
            vcount_r   <= '0;
            front_r    <= 1'b0;
            back_r     <= 1'b0;
            inovf_r    <= 1'b0;
            produced_r <= '0;
            state_r    <= S_LOAD;
          end else if (pcl_pkg::crosses(rd_i.side, rd_j.side)) begin
            rem_r   <= 50'(mag_i);
            den_r   <= 49'(mag_i) + 49'(mag_j);
            q_r     <= '0;
            qc_r    <= '0;
            state_r <= S_DIV;
          end else if (idx_next == vcount_r) begin
            vcount_r   <= '0;
            front_r    <= 1'b0;
            back_r     <= 1'b0;
            inovf_r    <= 1'b0;
            produced_r <= '0;
            state_r    <= S_LOAD;
          end else begin
            idx_r   <= idx_next[AW-1:0];
            state_r <= S_FETCH;
          end
        end
        S_DIV: begin
          rem_r <= rem_sub;
          q_r   <= {q_r[pcl_pkg::FRAC_W-2:0], q_bit};
          qc_r  <= qc_r + QC_W'(1);
          if (qc_r == QC_W'(pcl_pkg::FRAC_W - 1)) begin
            lc_r    <= '0;
            state_r <= S_LMUL;
          end
        end
        S_LMUL: begin
          prod_r  <= 64'(lmag) * 64'(q_r);
          neg_r   <= ldiff[32];
          state_r <= S_LADD;
        end
        S_LADD: begin
          lerp_r[lc_r] <= neg_r ? la - $signed(loff) : la + $signed(loff);
          lc_r         <= lc_r + 2'd1;
          state_r      <= (lc_r == 2'd2) ? S_EMITL : S_LMUL;
        end
        S_EMITL: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= {lerp_r[2], lerp_r[1], lerp_r[0]};
            out_last_r   <= (emit_inc == kept_r);
            out_culled_r <= 1'b0;
            out_ovf_r    <= ovf_r;
            emit_cnt_r   <= emit_inc;
            if (idx_next == vcount_r) begin
              vcount_r   <= '0;
              front_r    <= 1'b0;
              back_r     <= 1'b0;
              inovf_r    <= 1'b0;
              produced_r <= '0;
              state_r    <= S_LOAD;
            end else begin
              idx_r   <= idx_next[AW-1:0];
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // store fill never passes its depth
  a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CW'(MAX_VERTS))
    else $error("vertex count beyond store depth");

  // emitted results never exceed the kept count during a pass
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VTX || state_r == S_CHK || state_r == S_EMITL) |-> emit_cnt_r <= kept_r)
    else $error("more results emitted than kept");

  // divider remainder stays below the denominator
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < {1'b0, den_r})
    else $error("divider remainder out of range");

  // a culled result is alone, final and has zero coordinates
  a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_culled_r) |-> (out_last_r && out_data_r == '0))
    else $error("culled result malformed");

  // no vertex is taken during the divide or the interpolated emit
  a_no_load_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_EMITL) |-> !in_tready)
    else $error("input ready during emit pass");

endmodule
